// ===== rtl/spq_pkg.sv =====
`default_nettype none
package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OCC_W    = 5;

  typedef enum logic [1:0] {
    OP_INSERT    = 2'd0,
    OP_POP_HIGH  = 2'd1,
    OP_POP_LOW   = 2'd2,
    OP_REMOVE_ID = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE  = 1'b0,
    S_APPLY = 1'b1
  } state_t;

  typedef struct packed {
    op_t         operation;
    logic [15:0] entry_id;
    logic [7:0]  priority_req;
  } cmd_item_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] out_id;
    logic [7:0]  out_priority;
    logic [4:0]  occupancy;
  } result_item_t;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  prio;
  } entry_t;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic capture;
    logic apply;
    logic insert_en;
    op_t  op;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/spq_cell.sv =====
`default_nettype none
module spq_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire spq_pkg::cell_ctl_t ctl,
  input  wire spq_pkg::entry_t    req,
  input  wire spq_pkg::entry_t    new_entry,
  input  wire logic               left_ge,
  input  wire logic               left_valid,
  input  wire spq_pkg::entry_t    left_entry,
  input  wire logic               right_valid,
  input  wire spq_pkg::entry_t    right_entry,
  input  wire logic               seen_in,
  output spq_pkg::entry_t         entry,
  output logic                    valid,
  output logic                    ge,
  output logic                    seen_out,
  output spq_pkg::entry_t         taken
);
  import spq_pkg::*;

  logic kill;
  logic first;

  assign first    = kill & ~seen_in;
  assign seen_out = seen_in | kill;
  assign taken    = first ? entry : '0;

  // compare flags are taken at the accept edge, while the row is stable
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      ge <= valid & (entry.prio >= req.prio);
      case (ctl.op)
        OP_POP_HIGH:  kill <= valid;
        OP_POP_LOW:   kill <= valid & ~right_valid;
        OP_REMOVE_ID: kill <= valid & (entry.id == req.id);
        default:      kill <= 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.apply) begin
      if (ctl.op == OP_INSERT) begin
        if (ctl.insert_en && !ge) begin
          valid <= left_ge ? 1'b1 : left_valid;
        end
      end else if (seen_out) begin
        valid <= right_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.apply) begin
      if (ctl.op == OP_INSERT) begin
        if (ctl.insert_en && !ge) begin
          entry <= left_ge ? new_entry : left_entry;
        end
      end else if (seen_out) begin
        // close the gap: pull from the right neighbor
        entry <= right_entry;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sorted_priority_queue.sv =====
`default_nettype none
// Channel   Ports                        Beat
// command   start, busy, cmd             start high and busy low at a rising edge
// result    result_valid, result         one cycle with result_valid high
//
// Every command runs as follows: the accept edge latches compare flags in
// all cells, the next edge shifts the row of cells and registers the result.
// The result strobe shows in the cycle after that, when a new command may
// already be accepted. Reset empties the queue at once (valid bits only).
// The receiver cannot stall; busy alone holds off commands.
module sorted_priority_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire spq_pkg::cmd_item_t    cmd,
  output logic                       result_valid,
  output spq_pkg::result_item_t      result
);
  import spq_pkg::*;

  state_t state, state_next;
  cell_ctl_t ctl;
  logic accept;

  op_t              op_q;
  entry_t           new_q;
  logic             full_q;
  logic [CNT_W-1:0] count;

  entry_t               cmd_entry;
  entry_t               ents   [CAPACITY];
  entry_t               takens [CAPACITY];
  entry_t               lents  [CAPACITY];
  entry_t               rents  [CAPACITY];
  logic [CAPACITY-1:0]  vlds, ges, seens, lges, lvlds, rvlds, seen_ins;
  entry_t               taken_any;
  logic                 hit;

  assign accept    = start & ~busy;
  assign cmd_entry = '{id: cmd.entry_id, prio: cmd.priority_req};
  assign hit       = seens[CAPACITY-1];

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = S_APPLY;
      S_APPLY: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy          = (state == S_APPLY);
    ctl.capture   = accept;
    ctl.apply     = (state == S_APPLY);
    ctl.insert_en = ~full_q;
    ctl.op        = accept ? cmd.operation : op_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= cmd.operation;
      new_q  <= cmd_entry;
      full_q <= (count >= CNT_W'(CAPACITY));
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign lges[i]     = 1'b1;
      assign lvlds[i]    = 1'b1;
      assign lents[i]    = '0;
      assign seen_ins[i] = 1'b0;
    end else begin : g_mid
      assign lges[i]     = ges[i-1];
      assign lvlds[i]    = vlds[i-1];
      assign lents[i]    = ents[i-1];
      assign seen_ins[i] = seens[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign rvlds[i] = 1'b0;
      assign rents[i] = '0;
    end else begin : g_body
      assign rvlds[i] = vlds[i+1];
      assign rents[i] = ents[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .req         (cmd_entry),
      .new_entry   (new_q),
      .left_ge     (lges[i]),
      .left_valid  (lvlds[i]),
      .left_entry  (lents[i]),
      .right_valid (rvlds[i]),
      .right_entry (rents[i]),
      .seen_in     (seen_ins[i]),
      .entry       (ents[i]),
      .valid       (vlds[i]),
      .ge          (ges[i]),
      .seen_out    (seens[i]),
      .taken       (takens[i])
    );
  end

  // at most one cell drives a nonzero entry
  always_comb begin
    taken_any = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      taken_any = taken_any | takens[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      count        <= '0;
    end else begin
      result_valid <= (state == S_APPLY);
      if (state == S_APPLY) begin
        if (op_q == OP_INSERT) begin
          if (!full_q) count <= count + CNT_W'(1);
        end else if (hit) begin
          count <= count - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_APPLY) begin
      result.out_id       <= taken_any.id;
      result.out_priority <= taken_any.prio;
      if (op_q == OP_INSERT) begin
        result.status    <= full_q ? ST_FULL : ST_OK;
        result.occupancy <= OCC_W'(full_q ? count : count + CNT_W'(1));
      end else begin
        result.status    <= hit ? ST_OK : ST_MISS;
        result.occupancy <= OCC_W'(hit ? count - CNT_W'(1) : count);
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/spq_checker.sv =====
`default_nettype none
module spq_prop_checker (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  start,
  input wire logic                  busy,
  input wire spq_pkg::cmd_item_t    cmd,
  input wire logic                  result_valid,
  input wire spq_pkg::result_item_t result
);
  import spq_pkg::*;

  logic cmd_ok;
  assign cmd_ok = (cmd.operation == OP_INSERT) || (cmd.operation == OP_POP_HIGH)
               || (cmd.operation == OP_POP_LOW) || (cmd.operation == OP_REMOVE_ID);

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##2 result_valid)
    else $error("accepted command gave no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(start && !busy && cmd_ok, 2))
    else $error("result without a command");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after accept");

  a_full_occupancy: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == ST_FULL |-> result.occupancy == OCC_W'(CAPACITY))
    else $error("full reported below capacity");

  a_zero_payload: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != ST_OK |->
      result.out_id == '0 && result.out_priority == '0)
    else $error("payload on a failed operation");

endmodule

bind sorted_priority_queue spq_prop_checker u_spq_checker (.*);
`default_nettype wire

// ===== bench/spq_checker.sv =====
`timescale 1ns / 100ps
module spq_checker (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic                  busy,
  input  wire spq_pkg::cmd_item_t    cmd,
  input  wire logic                  result_valid,
  input  wire spq_pkg::result_item_t result,
  output int                         fail_count,
  output int                         pending,
  output int                         full_hits,
  output int                         miss_hits
);
  import spq_pkg::*;

  // entries held by the queue, head first
  entry_t       held_entries[$];
  result_item_t due_results[$];

  function automatic result_item_t sorted_outcome(input cmd_item_t c);
    result_item_t r;
    int           pos;
    int           hit;
    r        = '0;
    r.status = ST_MISS;
    hit      = -1;
    case (c.operation)
      OP_INSERT: begin
        if (held_entries.size() >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          // place after every entry of greater or equal priority
          pos = 0;
          while (pos < held_entries.size() && held_entries[pos].prio >= c.priority_req)
            pos++;
          held_entries.insert(pos, '{id: c.entry_id, prio: c.priority_req});
          r.status = ST_OK;
        end
      end
      OP_POP_HIGH: begin
        if (held_entries.size() != 0) hit = 0;
      end
      OP_POP_LOW: begin
        if (held_entries.size() != 0) hit = held_entries.size() - 1;
      end
      OP_REMOVE_ID: begin
        foreach (held_entries[i])
          if (hit < 0 && held_entries[i].id == c.entry_id) hit = i;
      end
      default: ;
    endcase
    if (hit >= 0) begin
      r.status       = ST_OK;
      r.out_id       = held_entries[hit].id;
      r.out_priority = held_entries[hit].prio;
      held_entries.delete(hit);
    end
    r.occupancy = 5'(held_entries.size());
    return r;
  endfunction

  always @(posedge clk) begin
    result_item_t want;
    if (rst) begin
      held_entries.delete();
      due_results.delete();
      pending = 0;
    end else begin
      // check the result beat before taking a new command
      if (result_valid) begin
        if (due_results.size() == 0) begin
          fail_count++;
          $display("%0t: result with none expected: status %0d id %h prio %h occupancy %0d",
                   $time, result.status, result.out_id, result.out_priority,
                   result.occupancy);
        end else begin
          want = due_results.pop_front();
          if (want.status == ST_FULL) full_hits++;
          if (want.status == ST_MISS) miss_hits++;
          if (result.status !== want.status || result.out_id !== want.out_id ||
              result.out_priority !== want.out_priority ||
              result.occupancy !== want.occupancy) begin
            fail_count++;
            $display("%0t: mismatch: expected status %0d id %h prio %h occupancy %0d",
                     $time, want.status, want.out_id, want.out_priority, want.occupancy);
            $display("%0t:           actual   status %0d id %h prio %h occupancy %0d",
                     $time, result.status, result.out_id, result.out_priority,
                     result.occupancy);
          end
        end
      end
      if (start && !busy) due_results.push_back(sorted_outcome(cmd));
      pending = due_results.size();
    end
  end

endmodule

// ===== bench/tb_sorted_priority_queue.sv =====
`timescale 1ns / 100ps
module tb_sorted_priority_queue;
  import spq_pkg::*;

  logic         clk;
  logic         rst   = 1'b1;
  logic         start = 1'b0;
  cmd_item_t    cmd   = '0;
  logic         busy;
  logic         result_valid;
  result_item_t result;

  int fail_count;
  int pending;
  int full_hits;
  int miss_hits;
  int sent;
  int idle_pct;

  int pace_plan[4]  = '{0, 81, 31, 0};
  int insert_mix[5] = '{90, 10, 50, 90, 70};

  sorted_priority_queue i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .result_valid (result_valid),
    .result       (result)
  );

  spq_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .result_valid (result_valid),
    .result       (result),
    .fail_count   (fail_count),
    .pending      (pending),
    .full_hits    (full_hits),
    .miss_hits    (miss_hits)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // drive one command beat and hold it until the block takes it
  task automatic send(input op_t op, input logic [15:0] id, input logic [7:0] pri);
    bit taken;
    // idle cycle by cycle before offering the beat
    while (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= '{operation: op, entry_id: id, priority_req: pri};
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
    sent++;
  endtask

  // hold off until every outstanding result has come back
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_id();
    if ($urandom_range(0, 99) < 75) return 16'($urandom_range(0, 7));
    return 16'($urandom());
  endfunction

  function automatic logic [7:0] pick_priority();
    if ($urandom_range(0, 99) < 60) return 8'($urandom_range(0, 3));
    return 8'($urandom());
  endfunction

  initial begin
    op_t op;
    repeat (9) @(posedge clk);
    rst      <= 1'b0;
    idle_pct = 0;

    // empty queue, single entry, extremes, ties and duplicate ids
    send(OP_POP_HIGH,  16'h0000, 8'h00);
    send(OP_POP_LOW,   16'hffff, 8'hff);
    send(OP_REMOVE_ID, 16'h0000, 8'h00);
    send(OP_INSERT,    16'hffff, 8'hff);
    send(OP_POP_LOW,   16'h0000, 8'h00);
    send(OP_INSERT,    16'h0000, 8'h00);
    send(OP_POP_HIGH,  16'hffff, 8'hff);
    send(OP_INSERT,    16'h0001, 8'h80);
    send(OP_INSERT,    16'h0002, 8'h80);
    send(OP_INSERT,    16'h0003, 8'hff);
    send(OP_INSERT,    16'h0004, 8'h00);
    send(OP_INSERT,    16'hffff, 8'h80);
    send(OP_INSERT,    16'h0002, 8'h10);
    send(OP_REMOVE_ID, 16'h1234, 8'h55);
    send(OP_REMOVE_ID, 16'h0002, 8'haa);
    send(OP_POP_HIGH,  16'h5555, 8'h00);
    send(OP_POP_HIGH,  16'h0000, 8'hff);
    send(OP_POP_LOW,   16'haaaa, 8'h00);
    send(OP_REMOVE_ID, 16'hffff, 8'h00);
    send(OP_REMOVE_ID, 16'h0002, 8'h00);
    send(OP_POP_LOW,   16'h0000, 8'h00);
    drain();

    foreach (pace_plan[p]) begin
      idle_pct = pace_plan[p];
      foreach (insert_mix[b]) begin
        repeat (22) begin
          if ($urandom_range(0, 99) < insert_mix[b]) op = OP_INSERT;
          else op = op_t'(2'($urandom_range(1, 3)));
          send(op, pick_id(), pick_priority());
        end
        if (b == 2) drain();
      end
    end

    drain();
    repeat (10) @(posedge clk);
    $display("Ran %0d commands under four pacing settings, full and empty queue included.",
             sent);
    $display("Inserts refused on a full queue: %0d; removes that found nothing: %0d.",
             full_hits, miss_hits);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
